### hw/rtl/ssm_pkg.sv
// ----------------------------------------------------------------------------
// ssm_pkg
// Types, constants and lookup functions shared by the seven segment LED
// strip mapper.
// ----------------------------------------------------------------------------
package ssm_pkg;

   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_LEDS_PER_SEGMENT = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LEDS_PER_PERIOD  = 4'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_START_LED        = 4'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WIRING_ORDER     = 4'd3;

   localparam logic [2:0] WIRING_EDCGFAB = 3'd0;
   localparam logic [2:0] WIRING_EDCBAFG = 3'd1;
   localparam logic [2:0] WIRING_GCDEFAB = 3'd2;
   localparam logic [2:0] WIRING_GBAFEDC = 3'd3;
   localparam logic [2:0] WIRING_FABGEDC = 3'd4;
   localparam logic [2:0] WIRING_FABCDEG = 3'd5;

   localparam logic [7:0] CHAR_NUL     = 8'h00;
   localparam logic [7:0] CHAR_PERIOD  = 8'h2E;
   localparam logic [7:0] CHAR_COLON   = 8'h3A;
   localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
   localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] UPPER_OFFSET = 8'h37;
   localparam logic [7:0] LOWER_OFFSET = 8'h57;

   typedef struct packed {
      logic [7:0] leds_per_segment;
      logic [7:0] leds_per_period;
      logic [15:0] start_led;
      logic [2:0] wiring_order;
   } cfg_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       frame_start;
   } req_type;

   typedef struct packed {
      logic [15:0] digit_led;
      logic [6:0]  blank_groups;
      logic        apply;
   } rsp_type;

   // segment mask of 0-9 then a-z
   function automatic logic [6:0] seg_lookup(logic [5:0] idx);
      logic [6:0] m;
      case (idx)
         6'd0:  m = 7'h77;
         6'd1:  m = 7'h11;
         6'd2:  m = 7'h6B;
         6'd3:  m = 7'h3B;
         6'd4:  m = 7'h1D;
         6'd5:  m = 7'h3E;
         6'd6:  m = 7'h7E;
         6'd7:  m = 7'h13;
         6'd8:  m = 7'h7F;
         6'd9:  m = 7'h1F;
         6'd10: m = 7'h5F;
         6'd11: m = 7'h7C;
         6'd12: m = 7'h66;
         6'd13: m = 7'h79;
         6'd14: m = 7'h6E;
         6'd15: m = 7'h4E;
         6'd16: m = 7'h76;
         6'd17: m = 7'h5D;
         6'd18: m = 7'h44;
         6'd19: m = 7'h71;
         6'd20: m = 7'h5E;
         6'd21: m = 7'h64;
         6'd22: m = 7'h27;
         6'd23: m = 7'h58;
         6'd24: m = 7'h77;
         6'd25: m = 7'h4F;
         6'd26: m = 7'h1F;
         6'd27: m = 7'h48;
         6'd28: m = 7'h3E;
         6'd29: m = 7'h6C;
         6'd30: m = 7'h75;
         6'd31: m = 7'h25;
         6'd32: m = 7'h7D;
         6'd33: m = 7'h2A;
         6'd34: m = 7'h3D;
         6'd35: m = 7'h6B;
         default: m = 7'h00;
      endcase
      return m;
   endfunction

   // exchange the n-bit group at lo with the n-bit group at hi
   function automatic logic [6:0] group_swap(logic [6:0] x, int lo, int hi, int n);
      logic [6:0] msk;
      logic [6:0] d;
      msk = 7'((1 << n) - 1);
      d = ((x >> lo) ^ (x >> hi)) & msk;
      return x ^ ((d << lo) | (d << hi));
   endfunction

endpackage

### hw/rtl/ssm_csr.sv
// ----------------------------------------------------------------------------
// ssm_csr
// Configuration registers written through the csr channel.
// ----------------------------------------------------------------------------
module ssm_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ssm_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [ssm_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   output ssm_pkg::cfg_type                   cfg
);

   ssm_pkg::cfg_type cfg_ff;
   ssm_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            ssm_pkg::CSR_LEDS_PER_SEGMENT: cfg_in.leds_per_segment = csr_wdata[7:0];
            ssm_pkg::CSR_LEDS_PER_PERIOD:  cfg_in.leds_per_period  = csr_wdata[7:0];
            ssm_pkg::CSR_START_LED:        cfg_in.start_led        = csr_wdata[15:0];
            ssm_pkg::CSR_WIRING_ORDER:     cfg_in.wiring_order     = csr_wdata[2:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.leds_per_segment <= 8'd1;
         cfg_ff.leds_per_period  <= 8'd1;
         cfg_ff.start_led        <= 16'd0;
         cfg_ff.wiring_order     <= ssm_pkg::WIRING_FABCDEG;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### hw/rtl/ssm_glyph.sv
// ----------------------------------------------------------------------------
// ssm_glyph
// Character to segment-group blank mask, in the LED order of the wiring.
// ----------------------------------------------------------------------------
module ssm_glyph (
   input  logic [7:0] char_code,
   input  logic [2:0] wiring_order,
   output logic [6:0] blank_groups
);

   logic [7:0] idx_wide;
   logic       known;
   logic [6:0] mask;
   logic [6:0] wired;

   always_comb begin
      known    = 1'b1;
      idx_wide = 8'd0;
      if (char_code >= ssm_pkg::CHAR_DIGIT_0 && char_code <= ssm_pkg::CHAR_DIGIT_9) begin
         idx_wide = char_code - ssm_pkg::CHAR_DIGIT_0;
      end else if (char_code >= ssm_pkg::CHAR_UPPER_A &&
                   char_code <= ssm_pkg::CHAR_UPPER_Z) begin
         idx_wide = char_code - ssm_pkg::UPPER_OFFSET;
      end else if (char_code >= ssm_pkg::CHAR_LOWER_A &&
                   char_code <= ssm_pkg::CHAR_LOWER_Z) begin
         idx_wide = char_code - ssm_pkg::LOWER_OFFSET;
      end else begin
         known = 1'b0;
      end
      mask = known ? ssm_pkg::seg_lookup(idx_wide[5:0]) : 7'h00;
   end

   always_comb begin
      wired = mask;
      unique case (wiring_order)
         ssm_pkg::WIRING_EDCBAFG: begin
            wired = ssm_pkg::group_swap(mask, 0, 3, 1);
            wired = ssm_pkg::group_swap(wired, 1, 2, 1);
         end
         ssm_pkg::WIRING_GCDEFAB: begin
            wired = ssm_pkg::group_swap(mask, 3, 6, 1);
            wired = ssm_pkg::group_swap(wired, 4, 5, 1);
         end
         ssm_pkg::WIRING_GBAFEDC: begin
            wired = ssm_pkg::group_swap(mask, 0, 4, 3);
            wired = ssm_pkg::group_swap(wired, 3, 6, 1);
            wired = ssm_pkg::group_swap(wired, 4, 5, 1);
         end
         ssm_pkg::WIRING_FABGEDC: begin
            wired = ssm_pkg::group_swap(mask, 0, 4, 3);
         end
         ssm_pkg::WIRING_FABCDEG: begin
            wired = ssm_pkg::group_swap(mask, 0, 4, 3);
            wired = ssm_pkg::group_swap(wired, 0, 3, 1);
            wired = ssm_pkg::group_swap(wired, 1, 2, 1);
         end
         default: wired = mask;
      endcase
   end

   // group k in LED order is mask bit 6-k; blank where unlit
   always_comb begin
      for (int k = 0; k < 7; k++) begin
         blank_groups[k] = ~wired[6-k];
      end
   end

endmodule

### hw/rtl/seven_segment_led_strip_mapper_core.sv
// ----------------------------------------------------------------------------
// seven_segment_led_strip_mapper_core
// Maps display characters onto an addressable LED strip: first LED of each
// digit and the segment groups to blank.
// ----------------------------------------------------------------------------
// One request is taken per clock while the response side keeps up, and each
// yields one response. A request is captured in an input register, then
// decoded and placed on the strip, and held in a response register until
// taken. The LED position carries from one request to the next through a
// register updated in the decode cycle. Configuration writes are taken at
// any time and should be made while no request is in flight. LED_INDEX_BITS
// sets the width of the position, which saturates at its top value; digit_led
// carries its low 16 bits.
// ----------------------------------------------------------------------------
module seven_segment_led_strip_mapper_core #(
   parameter int LED_INDEX_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  ssm_pkg::req_type                   req_payload,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output ssm_pkg::rsp_type                   rsp_payload,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ssm_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [ssm_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int PW = (LED_INDEX_BITS > 16) ? LED_INDEX_BITS : 16;
   localparam int SW = PW + 1;
   localparam logic [SW-1:0] LIM = (SW'(1) << LED_INDEX_BITS) - SW'(1);

   ssm_pkg::cfg_type cfg;

   logic                      in_valid_ff;
   ssm_pkg::req_type          in_ff;
   logic                      rsp_valid_ff;
   ssm_pkg::rsp_type          rsp_ff;
   ssm_pkg::rsp_type          rsp_in;
   logic [LED_INDEX_BITS-1:0] position_ff;
   logic [LED_INDEX_BITS-1:0] position_in;
   logic                      ended_ff;
   logic                      ended_in;

   logic                      work;
   logic [6:0]                blank;
   logic [SW-1:0]             start_ext;
   logic [LED_INDEX_BITS-1:0] base;
   logic                      ended_base;
   logic [10:0]               amount;
   logic [SW-1:0]             base_ext;
   logic [SW-1:0]             sum;
   logic [SW-1:0]             sum_sat;

   ssm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ssm_glyph u_glyph (
      .char_code    (in_ff.char_code),
      .wiring_order (cfg.wiring_order),
      .blank_groups (blank)
   );

   assign work        = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready   = !in_valid_ff || work;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      start_ext  = SW'(cfg.start_led);
      base       = in_ff.frame_start
                   ? ((start_ext > LIM) ? LIM[LED_INDEX_BITS-1:0]
                                        : start_ext[LED_INDEX_BITS-1:0])
                   : position_ff;
      ended_base = in_ff.frame_start ? 1'b0 : ended_ff;
      base_ext   = SW'(base);

      rsp_in      = '0;
      ended_in    = ended_base;
      amount      = 11'd0;
      if (ended_base) begin
         amount = 11'd0;
      end else if (in_ff.char_code == ssm_pkg::CHAR_NUL) begin
         ended_in = 1'b1;
      end else if (in_ff.char_code == ssm_pkg::CHAR_PERIOD) begin
         amount = 11'(cfg.leds_per_period);
      end else if (in_ff.char_code == ssm_pkg::CHAR_COLON) begin
         amount = {2'b00, cfg.leds_per_period, 1'b0};
      end else begin
         amount              = {cfg.leds_per_segment, 3'b000} - 11'(cfg.leds_per_segment);
         rsp_in.digit_led    = base_ext[15:0];
         rsp_in.blank_groups = blank;
         rsp_in.apply        = 1'b1;
      end

      sum         = base_ext + SW'(amount);
      sum_sat     = (sum > LIM) ? LIM : sum;
      position_in = sum_sat[LED_INDEX_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         position_ff  <= '0;
         ended_ff     <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (work) begin
            rsp_valid_ff <= 1'b1;
            position_ff  <= position_in;
            ended_ff     <= ended_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= req_payload;
      end
      if (work) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule
